// ----- rtl/core/multi_slot_tick_timer_table_core_assert.svh -----
// Assertion macros for the tick timer table core.
// Depends on nothing; users supply aclk and aresetn in scope.
`ifndef MULTI_SLOT_TICK_TIMER_TABLE_CORE_ASSERT_SVH
`define MULTI_SLOT_TICK_TIMER_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every aclk edge out of reset.
`define MSTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MSTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSTT_ASSERT_NOW(label, ante, cons, msg)
`define MSTT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/mstt_pkg.sv -----
// Shared types, codes and constants of the tick timer table.
// No dependencies.
package mstt_pkg;

    localparam int SLOTS_DEFAULT = 12;
    localparam int SLOTS_MAX     = 16;
    localparam int CMD_W         = 3;
    localparam int SLOT_W        = 4;
    localparam int COUNT_W       = 16;
    localparam int KIND_W        = 2;

    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELOAD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_MODE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOEXP  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count_value;
        logic               periodic;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot_out;
        logic              accepted;
        logic              last;
    } out_word_t;

    // One slot as held in the table memory.
    typedef struct packed {
        logic [COUNT_W-1:0] down_count;
        logic [COUNT_W-1:0] reload_count;
        logic               periodic;
    } slot_entry_t;

endpackage

// ----- rtl/core/mstt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/multi_slot_tick_timer_table_core.sv -----
// Order: a command's acknowledge word is registered from the execute state, which waits
// while the result register is full; a tick walks the table one slot per cycle unless a
// stall holds it, through the single read port of the slot memory, and its last word is
// registered from the finish state. No new command is taken until the core is idle again.
// Reset: aresetn (synchronous, active low) frees all slots at once via the valid
// flops; the slot memory needs no clearing pass.
module multi_slot_tick_timer_table_core #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mstt_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output mstt_pkg::out_word_t m_word
);

    `include "multi_slot_tick_timer_table_core_assert.svh"

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(mstt_pkg::slot_entry_t);

    typedef enum logic [1:0] {ST_IDLE, ST_CMD_EX, ST_WALK, ST_FIN} state_t;

    state_t                state_reg;
    mstt_pkg::in_word_t    in_reg;
    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic                  out_valid_reg;
    mstt_pkg::out_word_t   out_word_reg;

    // Walk pipeline: read issue index, slot whose data is on the RAM output,
    // and the expiry held back until we know whether it is the last one.
    logic [CW-1:0]         rd_idx_reg;
    logic                  p_valid_reg;
    logic [AW-1:0]         p_idx_reg;
    logic                  pend_valid_reg;
    logic [AW-1:0]         pend_idx_reg;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    mstt_pkg::slot_entry_t ram_wdata, ram_rdata;

    logic                  in_fire, can_emit, emit;
    mstt_pkg::out_word_t   emit_word;
    logic                  slot_in_range, target_ok, add_ok, any_free;
    logic [AW-1:0]         tgt_idx, free_idx;
    logic                  rd_more, rd_slot_valid;
    logic [mstt_pkg::COUNT_W-1:0] dec_count;
    logic                  expire, stall, advance;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_word   = out_word_reg;
    // The result register is free if empty or being drained this cycle.
    assign can_emit = !out_valid_reg || m_ready;

    // Target slot decode for remove, reload and set mode.
    assign slot_in_range = ({1'b0, in_reg.slot} < (mstt_pkg::SLOT_W + 1)'(SLOTS));
    assign tgt_idx       = slot_in_range ? in_reg.slot[AW-1:0] : '0;
    assign target_ok     = slot_in_range && valid_reg[tgt_idx];

    // First free slot, lowest index wins.
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = AW'(i);
                any_free = 1'b1;
            end
        end
    end
    assign add_ok = (in_reg.count_value != '0) && any_free;

    // Walk stage decode.
    assign rd_more       = (rd_idx_reg < CW'(SLOTS));
    assign rd_slot_valid = rd_more ? valid_reg[rd_idx_reg[AW-1:0]] : 1'b0;
    assign dec_count     = ram_rdata.down_count - mstt_pkg::COUNT_W'(1);
    assign expire        = p_valid_reg && (dec_count == '0);
    // Hold the walk when a second expiry needs the held one sent out first.
    assign stall         = expire && pend_valid_reg && !can_emit;
    assign advance       = (state_reg == ST_WALK) && !stall;

    always_comb begin
        ram_re     = 1'b0;
        ram_raddr  = '0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = ram_rdata;
        emit       = 1'b0;
        emit_word  = '0;
        valid_next = valid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // Fetch the target entry right away; ticks start the walk instead.
                ram_re    = in_fire && (s_word.command != mstt_pkg::CMD_TICK);
                ram_raddr = ({1'b0, s_word.slot} < (mstt_pkg::SLOT_W + 1)'(SLOTS))
                          ? s_word.slot[AW-1:0] : '0;
            end
            ST_CMD_EX: begin
                if (can_emit) begin
                    emit               = 1'b1;
                    emit_word.kind     = mstt_pkg::KIND_ACK;
                    emit_word.last     = 1'b1;
                    unique case (in_reg.command)
                        mstt_pkg::CMD_ADD: begin
                            emit_word.accepted = add_ok;
                            if (add_ok) begin
                                ram_we                 = 1'b1;
                                ram_waddr              = free_idx;
                                ram_wdata.down_count   = in_reg.count_value;
                                ram_wdata.reload_count = in_reg.count_value;
                                ram_wdata.periodic     = in_reg.periodic;
                                valid_next[free_idx]   = 1'b1;
                                emit_word.slot_out     = mstt_pkg::SLOT_W'(free_idx);
                            end
                        end
                        mstt_pkg::CMD_REMOVE: begin
                            emit_word.accepted = target_ok;
                            if (target_ok) begin
                                valid_next[tgt_idx] = 1'b0;
                            end
                        end
                        mstt_pkg::CMD_RELOAD: begin
                            emit_word.accepted = target_ok;
                            ram_we             = target_ok;
                            ram_waddr          = tgt_idx;
                            ram_wdata.down_count   = in_reg.count_value;
                            ram_wdata.reload_count = in_reg.count_value;
                        end
                        mstt_pkg::CMD_SET_MODE: begin
                            emit_word.accepted = target_ok;
                            ram_we             = target_ok;
                            ram_waddr          = tgt_idx;
                            ram_wdata.periodic = in_reg.periodic;
                        end
                        default: begin
                            emit_word.accepted = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                ram_re    = advance && rd_more;
                ram_raddr = rd_idx_reg[AW-1:0];
                if (advance && p_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = p_idx_reg;
                    if (!expire) begin
                        ram_wdata.down_count = dec_count;
                    end else if (ram_rdata.periodic) begin
                        ram_wdata.down_count = ram_rdata.reload_count;
                    end else begin
                        valid_next[p_idx_reg] = 1'b0;
                    end
                    // A newer expiry means the held one is not the last.
                    if (expire && pend_valid_reg) begin
                        emit               = 1'b1;
                        emit_word.kind     = mstt_pkg::KIND_EXPIRY;
                        emit_word.slot_out = mstt_pkg::SLOT_W'(pend_idx_reg);
                        emit_word.accepted = 1'b1;
                        emit_word.last     = 1'b0;
                    end
                end
            end
            ST_FIN: begin
                if (can_emit) begin
                    emit               = 1'b1;
                    emit_word.accepted = 1'b1;
                    emit_word.last     = 1'b1;
                    if (pend_valid_reg) begin
                        emit_word.kind     = mstt_pkg::KIND_EXPIRY;
                        emit_word.slot_out = mstt_pkg::SLOT_W'(pend_idx_reg);
                    end else begin
                        emit_word.kind     = mstt_pkg::KIND_NOEXP;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    mstt_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            p_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            rd_idx_reg     <= '0;
        end else begin
            valid_reg <= valid_next;

            // Result register: load a new word or drop the one taken.
            if (emit) begin
                out_valid_reg <= 1'b1;
                out_word_reg  <= emit_word;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        in_reg <= s_word;
                        if (s_word.command == mstt_pkg::CMD_TICK) begin
                            state_reg      <= ST_WALK;
                            rd_idx_reg     <= '0;
                            p_valid_reg    <= 1'b0;
                            pend_valid_reg <= 1'b0;
                        end else begin
                            state_reg <= ST_CMD_EX;
                        end
                    end
                end
                ST_CMD_EX: begin
                    if (can_emit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_WALK: begin
                    if (advance) begin
                        p_valid_reg <= rd_slot_valid;
                        p_idx_reg   <= rd_idx_reg[AW-1:0];
                        if (expire) begin
                            pend_valid_reg <= 1'b1;
                            pend_idx_reg   <= p_idx_reg;
                        end
                        if (rd_more) begin
                            rd_idx_reg <= rd_idx_reg + CW'(1);
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (can_emit) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MSTT_ASSERT_NOW(a_no_same_entry, ram_we && ram_re, ram_waddr != ram_raddr, "RAM read and write hit one entry")
    `MSTT_ASSERT_NOW(a_stage_slot_live, p_valid_reg, valid_reg[p_idx_reg], "walk stage holds a free slot")
    `MSTT_ASSERT_NOW(a_pend_in_tick, pend_valid_reg, (state_reg == ST_WALK) || (state_reg == ST_FIN), "held expiry outside a tick")
    `MSTT_ASSERT_NEXT(a_fin_last, (state_reg == ST_FIN) && can_emit, m_valid && m_word.last, "tick ended without a last word")

endmodule
